@@ src/dual_copy_record_checker_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dual copy record checker
// Shared same-cycle and next-cycle concurrent implication forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef DUAL_COPY_RECORD_CHECKER_CORE_ASSERT_SVH
`define DUAL_COPY_RECORD_CHECKER_CORE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define DCRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define DCRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// dcrc_pkg
// Codes, the result record type and the byte-wise CRC-16/MODBUS step.
// ----------------------------------------------------------------------------
`default_nettype none

package dcrc_pkg;

  localparam int unsigned REC_LEN_W = 11;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    FUNC_PRIMARY = 2'd0,
    FUNC_BACKUP  = 2'd1,
    FUNC_WRITE   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_CRC     = 2'd1,
    KIND_VERDICT = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VERD_OK             = 2'd0,
    VERD_BOTH_BAD       = 2'd1,
    VERD_RESTORE_PRIM   = 2'd2,
    VERD_RESTORE_BACKUP = 2'd3
  } verdict_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    verdict_t    verdict;
    logic        primary_ok;
    logic        backup_ok;
    logic        last;
  } result_t;

  // One byte through the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/dual_copy_record_checker_core.sv @@
// ----------------------------------------------------------------------------
// Dual copy record checker core
// Verifies a primary and backup record copy against their CRC-16/MODBUS
// checksums and generates the checksum for records being written.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in_ channel (in_func, in_data_byte). Primary copy
// bytes (data then checksum high, low) come first, then the backup copy;
// the backup's last checksum byte yields one verdict result. Write bytes are
// echoed, and the last data byte of a record also yields both CRC bytes.
// Results leave on the out_ channel, one per cycle while out_ready is high,
// with out_last marking the end of a verdict or write sequence. cfg_data sets
// the record length; the user must see it is written only while the block is
// idle, as the block does not enforce this. cfg_ready is always high. Each
// request is handled in the cycle it is accepted. The block takes one request
// per cycle while in_ready is high; the four-entry result queue sets the rate
// when a request produces three results, which drain at one per cycle while
// out_ready is high. Reset empties the result queue and clears sequence
// state; record length returns to 16. When the receiver stalls, results wait
// in the queue and in_ready drops once two or more are pending.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_copy_record_checker_core #(
  parameter int unsigned MAX_RECORD_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_data_byte,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  out_kind,
  output      logic [7:0]  out_byte,
  output      logic [1:0]  out_verdict,
  output      logic        out_primary_ok,
  output      logic        out_backup_ok,
  output      logic        out_last
);

  localparam int unsigned POS_W = $clog2(MAX_RECORD_BYTES + 3);
  localparam int unsigned CMP_W = (POS_W > dcrc_pkg::REC_LEN_W) ? POS_W : dcrc_pkg::REC_LEN_W;
  localparam logic [CMP_W-1:0] MAX_LEN_C = CMP_W'(MAX_RECORD_BYTES);
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic [10:0]         rec_len_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [1:0]          prev_func_r, prev_func_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [7:0]          stored_hi_r, stored_hi_nxt;
  logic [15:0]         prim_sum_r, prim_sum_nxt;
  logic                prim_ok_r, prim_ok_nxt;

  dcrc_pkg::result_t   q_r [Q_DEPTH];
  dcrc_pkg::result_t   q_nxt [Q_DEPTH];
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  dcrc_pkg::result_t   res [3];
  logic [1:0]          n_push;

  logic [CMP_W-1:0]    len_ext;
  logic [POS_W-1:0]    len, limit, p, p_inc;
  logic [15:0]         c, c_upd, sum;
  logic                restart, accept, pop, bok;
  dcrc_pkg::verdict_t  verd;
  logic [CNT_W-1:0]    base;

  assign cfg_ready = 1'b1;
  assign in_ready  = (cnt_r < CNT_W'(2));
  assign accept    = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;

  assign out_kind       = q_r[0].kind;
  assign out_byte       = q_r[0].data;
  assign out_verdict    = q_r[0].verdict;
  assign out_primary_ok = q_r[0].primary_ok;
  assign out_backup_ok  = q_r[0].backup_ok;
  assign out_last       = q_r[0].last;

  // Effective record length: zero acts as one, large values clamp to the maximum.
  assign len_ext = CMP_W'(rec_len_r);
  always_comb begin
    if (rec_len_r == '0) begin
      len = POS_W'(1);
    end else if (len_ext > MAX_LEN_C) begin
      len = POS_W'(MAX_LEN_C);
    end else begin
      len = POS_W'(len_ext);
    end
  end

  assign limit   = (in_func == dcrc_pkg::FUNC_WRITE) ? len : (len + POS_W'(2));
  assign restart = (in_func != prev_func_r) || (pos_r >= limit);
  assign p       = restart ? '0 : pos_r;
  assign c       = restart ? dcrc_pkg::CRC_INIT : crc_r;
  assign p_inc   = p + POS_W'(1);
  assign c_upd   = dcrc_pkg::crc16_byte(c, in_data_byte);
  assign sum     = {stored_hi_r, in_data_byte};
  assign bok     = (sum == c);

  always_comb begin
    if (!prim_ok_r && !bok) begin
      verd = dcrc_pkg::VERD_BOTH_BAD;
    end else if (!prim_ok_r) begin
      verd = dcrc_pkg::VERD_RESTORE_PRIM;
    end else if (!bok || (prim_sum_r != sum)) begin
      verd = dcrc_pkg::VERD_RESTORE_BACKUP;
    end else begin
      verd = dcrc_pkg::VERD_OK;
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    prev_func_nxt = prev_func_r;
    crc_nxt       = crc_r;
    stored_hi_nxt = stored_hi_r;
    prim_sum_nxt  = prim_sum_r;
    prim_ok_nxt   = prim_ok_r;
    n_push        = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '{kind: dcrc_pkg::KIND_ECHO, data: 8'h00, verdict: dcrc_pkg::VERD_OK,
                 primary_ok: 1'b0, backup_ok: 1'b0, last: 1'b0};
    end
    if (accept) begin
      prev_func_nxt = in_func;
      if (in_func == dcrc_pkg::FUNC_WRITE) begin
        crc_nxt     = c_upd;
        pos_nxt     = p_inc;
        res[0].data = in_data_byte;
        n_push      = 2'd1;
        if (p_inc == len) begin
          res[1].kind = dcrc_pkg::KIND_CRC;
          res[1].data = c_upd[15:8];
          res[2].kind = dcrc_pkg::KIND_CRC;
          res[2].data = c_upd[7:0];
          res[2].last = 1'b1;
          n_push      = 2'd3;
        end
      end else if (in_func != dcrc_pkg::FUNC_NONE) begin
        pos_nxt = p_inc;
        crc_nxt = c;
        if (p < len) begin
          crc_nxt = c_upd;
        end else if (p == len) begin
          stored_hi_nxt = in_data_byte;
        end else if (in_func == dcrc_pkg::FUNC_PRIMARY) begin
          prim_sum_nxt = sum;
          prim_ok_nxt  = bok;
        end else begin
          res[0].kind       = dcrc_pkg::KIND_VERDICT;
          res[0].verdict    = verd;
          res[0].primary_ok = prim_ok_r;
          res[0].backup_ok  = bok;
          res[0].last       = 1'b1;
          n_push            = 2'd1;
        end
      end
    end
  end

  // Result queue: entry 0 is the head; new results land right after the survivors.
  assign base    = cnt_r - CNT_W'(pop);
  assign cnt_nxt = base + CNT_W'(n_push);

  always_comb begin
    logic [CNT_W-1:0] jj;
    logic [CNT_W-1:0] idx;
    for (int j = 0; j < Q_DEPTH; j++) begin
      jj  = CNT_W'(j);
      idx = jj - base;
      if ((jj >= base) && (idx < CNT_W'(n_push))) begin
        q_nxt[j] = res[idx[1:0]];
      end else if (pop && (j < Q_DEPTH - 1)) begin
        q_nxt[j] = q_r[(j + 1) % Q_DEPTH];
      end else begin
        q_nxt[j] = q_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_len_r   <= 11'd16;
      pos_r       <= '0;
      prev_func_r <= dcrc_pkg::FUNC_PRIMARY;
      crc_r       <= dcrc_pkg::CRC_INIT;
      stored_hi_r <= 8'h00;
      prim_sum_r  <= 16'h0000;
      prim_ok_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rec_len_r <= cfg_data;
      end
      pos_r       <= pos_nxt;
      prev_func_r <= prev_func_nxt;
      crc_r       <= crc_nxt;
      stored_hi_r <= stored_hi_nxt;
      prim_sum_r  <= prim_sum_nxt;
      prim_ok_r   <= prim_ok_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < Q_DEPTH; j++) begin
      q_r[j] <= q_nxt[j];
    end
  end

endmodule

`default_nettype wire

@@ src/dcrc_checker.sv @@
// ----------------------------------------------------------------------------
// dcrc_checker
// Port-level checks on the result channel, bound to the checker core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_copy_record_checker_core_assert.svh"

module dcrc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_byte,
  input wire logic [1:0]  out_verdict,
  input wire logic        out_primary_ok,
  input wire logic        out_backup_ok,
  input wire logic        out_last
);

  logic        stalled;
  logic        is_verdict;
  logic        is_echo;
  logic        is_both_bad;
  logic        flags_clear;
  logic [14:0] out_word;

  assign stalled     = out_valid && !out_ready;
  assign is_verdict  = out_valid && (out_kind == dcrc_pkg::KIND_VERDICT);
  assign is_echo     = out_valid && (out_kind == dcrc_pkg::KIND_ECHO);
  assign is_both_bad = is_verdict && (out_verdict == dcrc_pkg::VERD_BOTH_BAD);
  assign flags_clear = (out_verdict == dcrc_pkg::VERD_OK) && !out_primary_ok && !out_backup_ok;
  assign out_word    = {out_kind, out_byte, out_verdict, out_primary_ok, out_backup_ok, out_last};

  // A stalled result must hold until it is taken.
  `DCRC_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(out_word), "result changed")

  // A verdict always closes its sequence and carries no byte.
  `DCRC_ASSERT_IMP(a_verdict_fmt, is_verdict, out_last && (out_byte == 8'h00), "bad verdict")

  // An echoed byte is never last and carries no verdict flags.
  `DCRC_ASSERT_IMP(a_echo_fmt, is_echo, !out_last && flags_clear, "bad echo")

  // A both-bad verdict must show both copy flags clear.
  `DCRC_ASSERT_IMP(a_verdict_flags, is_both_bad, !out_primary_ok && !out_backup_ok, "bad flags")

endmodule

bind dual_copy_record_checker_core dcrc_checker u_dcrc_checker (.*);

`default_nettype wire
